// File: rtl/core/vclpi_pkg.sv
// vclpi_pkg: shared types, constants and arithmetic helpers for the
// valve current-limit pi loop. no dependencies.
`default_nettype none

package vclpi_pkg;

	// fixed-point format of current, output and gains
	localparam int FRAC_BITS = 24;
	localparam int DATA_W    = 32;
	localparam int ACC_W     = 64;
	localparam int RND_W     = ACC_W - FRAC_BITS + 1;
	localparam int DRIVE_W   = 24;
	localparam int DUTY_W    = 15;
	localparam int GAIN_W    = 31;
	localparam int RAMP_W    = 24;
	localparam int IDX_W     = 3;

	localparam logic signed [DATA_W-1:0] OUT_MAX =
		DATA_W'((64'd1 << FRAC_BITS) - 64'd1);
	localparam logic signed [RND_W-1:0] ACC_MAX_RND =
		RND_W'(((64'd1 << FRAC_BITS) - 64'd1) >> 2);
	localparam logic signed [ACC_W-1:0] ACC_MAX_FULL =
		ACC_W'((((64'd1 << FRAC_BITS) - 64'd1) >> 2) << FRAC_BITS);

	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [ACC_W-1:0]  S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [ACC_W-1:0]  S64_MIN = 64'sh8000_0000_0000_0000;

	localparam logic [DUTY_W-1:0] DUTY_MAX = 15'h7FFF;

	// register reset values
	localparam logic signed [DATA_W-1:0] CUT_THRESHOLD_RST = -32'sd16777216;
	localparam logic [RAMP_W-1:0]        RAMP_STEP_RST     = 24'd16777;
	localparam logic [DUTY_W-1:0]        DEADBAND_RST      = 15'd256;

	typedef enum logic [IDX_W-1:0] {
		REG_GAIN_PROP       = 3'd0,
		REG_GAIN_INT        = 3'd1,
		REG_GAIN_ANTIWINDUP = 3'd2,
		REG_CURRENT_LIMIT   = 3'd3,
		REG_CUT_THRESHOLD   = 3'd4,
		REG_RAMP_STEP       = 3'd5,
		REG_DEADBAND_OFFSET = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_OPEN   = 2'd0,
		MODE_CLOSED = 2'd1,
		MODE_CUT    = 2'd2
	} loop_mode_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] current_ref;
		logic signed [DATA_W-1:0] current_fdb;
	} in_t;

	typedef struct packed {
		logic [DRIVE_W-1:0] drive_level;
		logic [DUTY_W-1:0]  duty_cmd;
		logic [1:0]         loop_mode;
		logic               cut_flag;
	} out_t;

	// saturate a sign-extended value to the signed 32 bit range
	function automatic logic signed [DATA_W-1:0] clamp32(input logic signed [ACC_W-1:0] v);
		logic fits;
		fits = (v[ACC_W-1:DATA_W-1] == {(ACC_W-DATA_W+1){v[DATA_W-1]}});
		if (fits)
			return v[DATA_W-1:0];
		return v[ACC_W-1] ? S32_MIN : S32_MAX;
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_add64(input logic signed [ACC_W-1:0] a,
			input logic signed [ACC_W-1:0] b);
		logic [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1])
			return s[ACC_W] ? S64_MIN : S64_MAX;
		return s[ACC_W-1:0];
	endfunction

	// floor shift by the fraction bits, plus round-half-up bit
	function automatic logic signed [RND_W-1:0] round_acc(input logic signed [ACC_W-1:0] acc);
		logic signed [RND_W-1:0] t;
		logic signed [RND_W-1:0] h;
		t = RND_W'(acc >>> FRAC_BITS);
		h = $signed({{(RND_W-1){1'b0}}, acc[FRAC_BITS-1]});
		return t + h;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/valve_current_limit_pi_loop.sv
// valve current-limit pi loop: open-loop and cut ticks go from the decision
// step straight to the final step; closed-loop limiting ticks run the pi path.
// one item at a time: a new item is taken only once the last has left the
// final step; the single 32x32 multiplier is used three times in sequence
// per closed-loop tick. a pending result may wait in the output register
// while the next item runs. async reset clears integrator, output state and
// loads register defaults. depends on vclpi_pkg and vclpi_mul.
`default_nettype none

module valve_current_limit_pi_loop (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire vclpi_pkg::in_t                      in_data,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output vclpi_pkg::out_t                          out_data,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [vclpi_pkg::IDX_W-1:0]         cfg_index,
	input  wire logic [vclpi_pkg::DATA_W-1:0]        cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL_P,
		ST_UP,
		ST_MUL_I,
		ST_ACC_I,
		ST_ACC_W,
		ST_CLAMP,
		ST_OUT_C,
		ST_FIN
	} state_t;

	state_t state_q;

	// configuration registers
	logic [vclpi_pkg::GAIN_W-1:0]        gain_prop_q;
	logic [vclpi_pkg::GAIN_W-1:0]        gain_int_q;
	logic [vclpi_pkg::GAIN_W-1:0]        gain_aw_q;
	logic [vclpi_pkg::GAIN_W-1:0]        limit_q;
	logic signed [vclpi_pkg::DATA_W-1:0] cut_thr_q;
	logic [vclpi_pkg::RAMP_W-1:0]        ramp_q;
	logic [vclpi_pkg::DUTY_W-1:0]        deadband_q;

	// loop state
	logic signed [vclpi_pkg::ACC_W-1:0]  acc_q;
	logic signed [vclpi_pkg::DATA_W-1:0] presat_q;
	logic signed [vclpi_pkg::DATA_W-1:0] sat_diff_q;

	// per-item working registers
	vclpi_pkg::in_t                      item_q;
	logic signed [vclpi_pkg::DATA_W-1:0] err_q;
	logic signed [vclpi_pkg::DATA_W-1:0] up_q;
	vclpi_pkg::loop_mode_t               mode_q;
	logic                                cut_q;
	logic                                out_valid_q;
	vclpi_pkg::out_t                     out_q;

	// shared multiplier
	logic [vclpi_pkg::GAIN_W-1:0]        mul_gain;
	logic signed [vclpi_pkg::DATA_W-1:0] mul_opnd;
	logic signed [vclpi_pkg::ACC_W-1:0]  prod;

	// tick decisions and helpers
	logic                                is_closed;
	logic                                is_cut;
	logic signed [vclpi_pkg::DATA_W-1:0] limit_s;
	logic signed [vclpi_pkg::DATA_W:0]   ramp_sum;
	logic signed [vclpi_pkg::DATA_W-1:0] presat_open;
	logic signed [vclpi_pkg::RND_W-1:0]  acc_rnd;
	logic signed [vclpi_pkg::RND_W:0]    out_sum;

	// output stage
	logic [vclpi_pkg::FRAC_BITS-1:0]     drive;
	logic signed [vclpi_pkg::DATA_W:0]   diff_wide;
	logic [vclpi_pkg::DUTY_W-1:0]        duty_raw;
	logic [vclpi_pkg::DUTY_W:0]          duty_sum;
	logic [vclpi_pkg::DUTY_W-1:0]        duty;
	logic                                out_free;

	vclpi_mul u_mul (
		.clk     (clk),
		.gain    (mul_gain),
		.operand (mul_opnd),
		.prod    (prod)
	);

	always_comb begin
		unique case (state_q)
			ST_MUL_I: begin
				mul_gain = gain_int_q;
				mul_opnd = up_q;
			end
			ST_ACC_I: begin
				mul_gain = gain_aw_q;
				mul_opnd = sat_diff_q;
			end
			default: begin
				mul_gain = gain_prop_q;
				mul_opnd = err_q;
			end
		endcase
	end

	assign limit_s   = $signed({1'b0, limit_q});
	assign is_closed = item_q.current_fdb > limit_s;
	assign is_cut    = item_q.current_fdb < cut_thr_q;

	// open-loop ramp up to the reference, saturating at the top; else set to it
	assign ramp_sum = {presat_q[vclpi_pkg::DATA_W-1], presat_q}
		+ $signed({{(vclpi_pkg::DATA_W+1-vclpi_pkg::RAMP_W){1'b0}}, ramp_q});
	always_comb begin
		if (presat_q < item_q.current_ref)
			presat_open = vclpi_pkg::clamp32(vclpi_pkg::ACC_W'(ramp_sum));
		else
			presat_open = item_q.current_ref;
	end

	assign acc_rnd = vclpi_pkg::round_acc(acc_q);
	assign out_sum = vclpi_pkg::RND_W'(up_q) + acc_rnd;

	// output saturation, saturation difference and duty conversion
	always_comb begin
		if (presat_q > vclpi_pkg::OUT_MAX)
			drive = vclpi_pkg::OUT_MAX[vclpi_pkg::FRAC_BITS-1:0];
		else if (presat_q < 0)
			drive = '0;
		else
			drive = presat_q[vclpi_pkg::FRAC_BITS-1:0];
		diff_wide = $signed({{(vclpi_pkg::DATA_W+1-vclpi_pkg::FRAC_BITS){1'b0}}, drive})
			- {presat_q[vclpi_pkg::DATA_W-1], presat_q};
		duty_raw = vclpi_pkg::DUTY_W'(drive >> (vclpi_pkg::FRAC_BITS - vclpi_pkg::DUTY_W));
		duty_sum = {1'b0, duty_raw} + {1'b0, deadband_q};
		if (duty_raw == '0)
			duty = deadband_q;
		else if (duty_sum[vclpi_pkg::DUTY_W])
			duty = vclpi_pkg::DUTY_MAX;
		else
			duty = duty_sum[vclpi_pkg::DUTY_W-1:0];
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			presat_q    <= '0;
			sat_diff_q  <= '0;
			mode_q      <= vclpi_pkg::MODE_OPEN;
			cut_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// the final step reloads the output register itself
			if (out_valid_q && !out_stall && (state_q != ST_FIN))
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					err_q <= limit_s - item_q.current_fdb;
					if (is_closed) begin
						mode_q  <= vclpi_pkg::MODE_CLOSED;
						cut_q   <= 1'b0;
						state_q <= ST_MUL_P;
					end else if (is_cut) begin
						mode_q  <= vclpi_pkg::MODE_CUT;
						cut_q   <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						mode_q   <= vclpi_pkg::MODE_OPEN;
						cut_q    <= 1'b0;
						presat_q <= presat_open;
						acc_q    <= vclpi_pkg::ACC_W'(presat_open) <<< vclpi_pkg::FRAC_BITS;
						state_q  <= ST_FIN;
					end
				end
				ST_MUL_P: begin
					state_q <= ST_UP;
				end
				ST_UP: begin
					up_q    <= vclpi_pkg::clamp32(prod >>> vclpi_pkg::FRAC_BITS);
					state_q <= ST_MUL_I;
				end
				ST_MUL_I: begin
					state_q <= ST_ACC_I;
				end
				ST_ACC_I: begin
					acc_q   <= vclpi_pkg::sat_add64(acc_q, prod);
					state_q <= ST_ACC_W;
				end
				ST_ACC_W: begin
					acc_q   <= vclpi_pkg::sat_add64(acc_q, prod);
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					if (acc_rnd > vclpi_pkg::ACC_MAX_RND)
						acc_q <= vclpi_pkg::ACC_MAX_FULL;
					else if (acc_rnd < 0)
						acc_q <= '0;
					state_q <= ST_OUT_C;
				end
				ST_OUT_C: begin
					presat_q <= vclpi_pkg::clamp32(vclpi_pkg::ACC_W'(out_sum));
					state_q  <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						sat_diff_q        <= vclpi_pkg::clamp32(vclpi_pkg::ACC_W'(diff_wide));
						out_q.drive_level <= vclpi_pkg::DRIVE_W'(drive);
						out_q.duty_cmd    <= duty;
						out_q.loop_mode   <= mode_q;
						out_q.cut_flag    <= cut_q;
						out_valid_q       <= 1'b1;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q <= '0;
			gain_int_q  <= '0;
			gain_aw_q   <= '0;
			limit_q     <= '0;
			cut_thr_q   <= vclpi_pkg::CUT_THRESHOLD_RST;
			ramp_q      <= vclpi_pkg::RAMP_STEP_RST;
			deadband_q  <= vclpi_pkg::DEADBAND_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				vclpi_pkg::REG_GAIN_PROP:       gain_prop_q <= cfg_data[vclpi_pkg::GAIN_W-1:0];
				vclpi_pkg::REG_GAIN_INT:        gain_int_q  <= cfg_data[vclpi_pkg::GAIN_W-1:0];
				vclpi_pkg::REG_GAIN_ANTIWINDUP: gain_aw_q   <= cfg_data[vclpi_pkg::GAIN_W-1:0];
				vclpi_pkg::REG_CURRENT_LIMIT:   limit_q     <= cfg_data[vclpi_pkg::GAIN_W-1:0];
				vclpi_pkg::REG_CUT_THRESHOLD:   cut_thr_q   <= $signed(cfg_data);
				vclpi_pkg::REG_RAMP_STEP:       ramp_q      <= cfg_data[vclpi_pkg::RAMP_W-1:0];
				vclpi_pkg::REG_DEADBAND_OFFSET: deadband_q  <= cfg_data[vclpi_pkg::DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a transfer in always starts the decision step
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_CHECK))
		else $error("input transfer did not start a tick");

	// a new result appears only from the final step
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIN))
		else $error("result raised outside final step");

	// integrator is within its clamp before the output sum
	a_acc_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT_C) |-> (!acc_rnd[vclpi_pkg::RND_W-1]
			&& (acc_rnd <= vclpi_pkg::ACC_MAX_RND)))
		else $error("integrator out of clamp range");

	// cut flag and cut mode travel together
	a_cut_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.loop_mode == vclpi_pkg::MODE_CUT) == out_data.cut_flag))
		else $error("cut flag and loop mode disagree");

endmodule

`default_nettype wire

// File: rtl/core/vclpi_mul.sv
// vclpi_mul: shared registered multiplier, unsigned gain times signed operand.
// depends on vclpi_pkg.
`default_nettype none

module vclpi_mul (
	input  wire logic                                 clk,
	input  wire logic [vclpi_pkg::GAIN_W-1:0]         gain,
	input  wire logic signed [vclpi_pkg::DATA_W-1:0]  operand,
	output logic signed [vclpi_pkg::ACC_W-1:0]        prod
);

	logic signed [vclpi_pkg::DATA_W-1:0] gain_s;
	logic signed [vclpi_pkg::ACC_W-1:0]  mul;

	assign gain_s = $signed({1'b0, gain});
	assign mul = gain_s * operand;

	always_ff @(posedge clk) begin
		prod <= mul;
	end

endmodule

`default_nettype wire
